// ----- rtl/core/rwns_pkg.sv -----
// Package for the rate-weighted node selector.
// Holds the node count, field widths, command codes and the controller/datapath structs.
// No dependencies.
package rwns_pkg;

    // Table size and derived index width.
    localparam int NODES   = 1024;
    localparam int IDX_W   = $clog2(NODES);

    // Field widths of the input and result words.
    localparam int CMD_W   = 1;
    localparam int NODE_W  = 10;
    localparam int RATE_W  = 17;
    localparam int FRAC_W  = 16;
    localparam int SUM_W   = 27;

    // Exact running total and the product of fraction and total.
    localparam int TOTAL_W = $clog2(longint'(NODES) * 64'd65536 + 64'd1);
    localparam int THR_W   = FRAC_W + TOTAL_W;

    // Rate of 1.0 in Q1.16 and the largest value of the rate_sum field.
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);
    localparam longint            SUM_MAX  = (64'd1 << SUM_W) - 64'd1;

    // Command codes of the input word.
    localparam logic [CMD_W-1:0] CMD_SET    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;   // input word may be accepted
        logic load_item;  // capture the input word
        logic clr;        // clearing pass: zero one table entry
        logic rd_item;    // read the addressed node's old rate
        logic set_wr;     // update total and write the new rate
        logic mul;        // form the threshold and start the scan
        logic scan;       // accumulate one rate
        logic out_load;   // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_end;    // last entry is being cleared
        logic total_zero; // running total is zero
        logic scan_end;   // node found or last node reached
        logic out_free;   // output register can take a word
    } t_stat;

endpackage

// ----- rtl/core/rwns_in_if.sv -----
// Input channel of the rate-weighted node selector: valid/ready plus the item fields.
// Depends on rwns_pkg.
interface rwns_in_if import rwns_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node_index;
    logic [RATE_W-1:0]   rate_value;
    logic [FRAC_W-1:0]   random_fraction;

    modport source (output valid, cmd, node_index, rate_value, random_fraction,
                    input ready);
    modport sink   (input valid, cmd, node_index, rate_value, random_fraction,
                    output ready);
endinterface

// ----- rtl/core/rwns_out_if.sv -----
// Result channel of the rate-weighted node selector: valid/ready plus the result fields.
// Depends on rwns_pkg.
interface rwns_out_if import rwns_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [NODE_W-1:0]   chosen_node;
    logic [SUM_W-1:0]    rate_sum;

    modport source (output valid, found, chosen_node, rate_sum, input ready);
    modport sink   (input valid, found, chosen_node, rate_sum, output ready);
endinterface

// ----- rtl/core/rwns_ctrl.sv -----
// Controller of the rate-weighted node selector: one-hot state machine issuing datapath commands.
// Depends on rwns_pkg (t_cmd, t_stat, command codes).
module rwns_ctrl import rwns_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SET_RD = 7'b0000100,
        S_SET_WR = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass over the rate table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_in_cmd == CMD_SELECT) ? S_MUL : S_SET_RD;
                end
            end
            S_SET_RD: begin
                o_cmd.rd_item = 1'b1;
                n_state = S_SET_WR;
            end
            S_SET_WR: begin
                o_cmd.set_wr = 1'b1;
                n_state = S_DONE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = i_stat.total_zero ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rwns_dp.sv -----
// Datapath of the rate-weighted node selector: rate table memory, total, threshold multiply,
// prefix-sum scan and the output register. Depends on rwns_pkg and rwns_out_if.
module rwns_dp import rwns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [NODE_W-1:0] i_node_index,
    input  logic [RATE_W-1:0] i_rate_value,
    input  logic [FRAC_W-1:0] i_random_fraction,
    output t_stat             o_stat,
    rwns_out_if.source        o_out
);

    // Rate table, read with a registered port.
    logic [RATE_W-1:0]  r_mem [NODES];
    logic [RATE_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [RATE_W-1:0]  wr_data;
    logic               wr_en;

    // Captured item.
    logic [NODE_W-1:0]  r_node_idx;
    logic [RATE_W-1:0]  r_rate;
    logic [FRAC_W-1:0]  r_frac;
    logic               idx_ok;

    // Running total, threshold and scan state.
    logic [TOTAL_W-1:0] r_total;
    logic [THR_W-1:0]   r_thr;
    logic [TOTAL_W-1:0] r_acc;
    logic [TOTAL_W-1:0] acc_next;
    logic [IDX_W-1:0]   r_scan_idx;
    logic [IDX_W-1:0]   r_clr_idx;
    logic               hit;
    logic               scan_last;

    // Result held until the output register is free.
    logic               r_found;
    logic [IDX_W-1:0]   r_chosen;

    // Output register.
    logic               r_out_valid;
    logic               r_out_found;
    logic [NODE_W-1:0]  r_out_node;
    logic [SUM_W-1:0]   r_out_sum;
    logic [SUM_W-1:0]   sum_field;

    assign idx_ok    = 32'(r_node_idx) < 32'(NODES);
    assign acc_next  = r_acc + TOTAL_W'(r_rd_data);
    assign hit       = {acc_next, FRAC_W'(0)} >= r_thr;
    assign scan_last = r_scan_idx == IDX_W'(NODES - 1);
    assign sum_field = (64'(r_total) > 64'(SUM_MAX)) ? SUM_W'(SUM_MAX) : SUM_W'(r_total);

    // Memory address and write selection.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_idx;
        wr_data = '0;
        rd_addr = r_scan_idx + IDX_W'(1);
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.set_wr) begin
            wr_en   = idx_ok;
            wr_addr = IDX_W'(r_node_idx);
            wr_data = r_rate;
        end
        if (i_cmd.rd_item) begin
            rd_addr = IDX_W'(r_node_idx);
        end else if (i_cmd.mul) begin
            rd_addr = '0;
        end
    end

    // Rate table memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Item capture; the rate is saturated to 1.0 on the way in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_node_idx <= i_node_index;
            r_rate     <= (i_rate_value > RATE_ONE) ? RATE_ONE : i_rate_value;
            r_frac     <= i_random_fraction;
        end
    end

    // Clearing pass counter and running total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_total   <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (i_cmd.set_wr && idx_ok) begin
                r_total <= r_total - TOTAL_W'(r_rd_data) + TOTAL_W'(r_rate);
            end
        end
    end

    // Threshold multiply, prefix-sum scan and result capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_thr      <= THR_W'(r_frac) * THR_W'(r_total);
            r_acc      <= '0;
            r_scan_idx <= '0;
            r_found    <= 1'b0;
            r_chosen   <= '0;
        end else if (i_cmd.set_wr) begin
            r_found  <= 1'b0;
            r_chosen <= '0;
        end else if (i_cmd.scan) begin
            r_acc      <= acc_next;
            r_scan_idx <= r_scan_idx + IDX_W'(1);
            if (hit || scan_last) begin
                r_found  <= 1'b1;
                r_chosen <= r_scan_idx;
            end
        end
    end

    // Output register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_node  <= NODE_W'(r_chosen);
            r_out_sum   <= sum_field;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.chosen_node = r_out_node;
    assign o_out.rate_sum    = r_out_sum;

    // Status back to the controller.
    assign o_stat.clr_end    = r_clr_idx == IDX_W'(NODES - 1);
    assign o_stat.total_zero = r_total == '0;
    assign o_stat.scan_end   = hit || scan_last;
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

endmodule

// ----- rtl/core/rate_weighted_node_select.sv -----
// Top level of the rate-weighted node selector: controller plus datapath.
// Depends on rwns_pkg, rwns_in_if, rwns_out_if, rwns_ctrl and rwns_dp.
//
// Roulette-wheel choice of a node by per-node rate (Q1.16, saturated at 1.0). After reset the
// block runs a clearing pass over the rate table before it takes the first word. One word is
// handled at a time, and every word gives one result word. A set word goes through table read,
// table and total update and output load before the next word is accepted. A select word forms
// fraction times total in a multiply step and then scans the rate table one node per cycle until
// the node is found or the last node is reached; with a zero total it skips the scan. The result
// sits in an output register, so the next word is accepted while the previous result waits to
// be taken.
module rate_weighted_node_select import rwns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwns_in_if.sink    i_in,
    rwns_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_in.ready = w_cmd.in_ready;

    // Sequencer.
    rwns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Table, total, scan and output register.
    rwns_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_node_index      (i_in.node_index),
        .i_rate_value      (i_in.rate_value),
        .i_random_fraction (i_in.random_fraction),
        .o_stat            (w_stat),
        .o_out             (o_out)
    );

    // A loaded result is presented in the following cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out.valid)
        else $error("result word not presented after load");

    // A found node implies a nonzero total in the same word.
    a_found_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.rate_sum != '0))
        else $error("node found with zero rate total");

    // No input word is taken while a scan or the clearing pass is running.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan || w_cmd.clr) |-> !i_in.ready)
        else $error("input accepted while busy");

endmodule
